[rtl/etg_pkg.sv]
// Shared constants, codes and control types of the eased tween generator.
`default_nettype none

package etg_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TIME_BITS  = 48;
    localparam int DUR_W      = 16;
    localparam int MODE_W     = 3;
    localparam int VAL_W      = 32;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROG_W     = FRAC_BITS + 1;
    localparam int MS_DIV     = 1000;
    // A quotient by 1000 needs at least nine bits fewer than the timestamp.
    localparam int MS_W       = TIME_BITS - 9;
    localparam int DIV_W      = DUR_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int P1_W       = 2 * FRAC_BITS + 1;
    localparam int MA_W       = (P1_W + 1 > DIFF_W + 1) ? P1_W + 1 : DIFF_W + 1;
    localparam int MB_W       = FRAC_BITS + 2;
    localparam int PR_W       = MA_W + MB_W;
    localparam int TOT_W      = PR_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = ((TIME_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VAL_W + PROG_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    // Milliseconds come from a reciprocal multiplication on sixteen bits of
    // the timestamp at a time. The remainder carried between steps is below
    // 1000, so each partial dividend fits 26 bits, and a reciprocal rounded up
    // at a 36-bit scale gives the exact floor over that whole range.
    localparam int MS_CHUNK_W = 16;
    localparam int MS_STEPS   = TIME_BITS / MS_CHUNK_W;
    localparam int MS_REM_W   = 10;
    localparam int MS_PART_W  = MS_REM_W + MS_CHUNK_W;
    localparam int MS_SHIFT   = 36;
    localparam int MS_RECIP_W = 27;
    localparam int MS_PHASE_W = $clog2(2 * MS_STEPS);

    localparam logic [PROG_W-1:0] ONE_Q   = PROG_W'(1) << FRAC_BITS;
    localparam logic [PROG_W-1:0] HALF_Q  = ONE_Q >> 1;
    localparam logic [PROG_W:0]   TWO_Q   = (PROG_W + 1)'(1) << (FRAC_BITS + 1);
    localparam logic [PR_W-1:0]   ONE_SQ  = PR_W'(1) << (2 * FRAC_BITS);
    localparam logic [MS_RECIP_W-1:0] MS_RECIP =
        MS_RECIP_W'(((64'd1 << MS_SHIFT) + 64'(MS_DIV) - 64'd1) / 64'(MS_DIV));
    localparam logic [MS_REM_W-1:0]   MS_THOUSAND = MS_REM_W'(MS_DIV);

    localparam logic [DUR_W-1:0]  DUR_RESET  = DUR_W'(250);
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(2);

    // Curve selection codes; the two unused codes fall back to linear.
    localparam logic [MODE_W-1:0] CURVE_LINEAR    = 3'd0;
    localparam logic [MODE_W-1:0] CURVE_IN_QUAD   = 3'd1;
    localparam logic [MODE_W-1:0] CURVE_INOUT_QUAD = 3'd2;
    localparam logic [MODE_W-1:0] CURVE_OUT_QUAD  = 3'd3;
    localparam logic [MODE_W-1:0] CURVE_IN_CUBIC  = 3'd4;
    localparam logic [MODE_W-1:0] CURVE_OUT_CUBIC = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 2'd3;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [1:0] {
        MUL_FIRST,
        MUL_CUBE,
        MUL_INTERP
    } mul_op_t;

    typedef struct packed {
        logic    in_load;
        logic    ms_start;
        logic    div_start;
        logic    load_start;
        logic    res_zero;
        logic    set_x_one;
        logic    load_x;
        logic    mul_en;
        mul_op_t mul_op;
        logic    alpha_en;
        logic    total_en;
        logic    commit_frame;
        logic    out_load;
    } etg_cmd_t;

    typedef struct packed {
        logic kind_start;
        logic active;
        logic elapsed_ge;
        logic ms_done;
        logic div_done;
        logic cubic;
        logic out_free;
    } etg_status_t;

endpackage

`default_nettype wire

[rtl/eased_tween_generator.sv]
// Top level of the eased tween generator.
`default_nettype none

// Each input transfer yields exactly one result transfer. A start item
// (tuser 0) stores its timestamp in milliseconds and arms the animation; a
// frame item (tuser 1) computes the clamped progress, shapes it by the selected
// easing curve and interpolates between the start and end registers, and a
// frame that arrives while idle yields zeros. One item at a time is processed.
// A finished item waits until the output register is free or being emptied.
// The millisecond conversion takes each 16-bit slice of the timestamp in
// turn, forming a quotient digit and then the new remainder; the progress
// fraction comes from a bit-serial divider with 32 quotient bits; the easing
// and the interpolation take five or six single-multiplier steps. A new input
// transfer is taken while a finished result still waits at the output.
// Configuration writes are taken on every cycle and must only be issued while
// no item is in flight.
module eased_tween_generator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [etg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [etg_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [etg_pkg::S_TDATA_W-1:0]      s_tdata,  // [47:0] time_us
    input  wire logic                               s_tuser,  // [0] kind
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [etg_pkg::M_TDATA_W-1:0]      m_tdata,  // [31:0] value, [48:32] progress
    output logic      [etg_pkg::M_TUSER_W-1:0]      m_tuser   // [0] changed, [1] running
);
    import etg_pkg::*;

    etg_cmd_t    cmd;
    etg_status_t status;
    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    etg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    etg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[rtl/etg_div.sv]
// Restoring divider that produces one quotient bit per clock cycle.
`default_nettype none

module etg_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [etg_pkg::DIV_W-1:0]     dividend,
    input  wire logic [etg_pkg::DUR_W-1:0]     divisor,
    output logic      [etg_pkg::DIV_W-1:0]     quotient,
    output logic                               done
);
    import etg_pkg::*;

    logic [DUR_W-1:0]     rem_reg, rem_next;
    logic [DUR_W-1:0]     dvs_reg;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DUR_W:0]       trial;
    logic [DUR_W:0]       trial_sub;
    logic                 fits;

    // The remainder stays below the divisor, so the trial value is below twice it.
    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = fits ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
        quo_next  = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

[rtl/etg_datapath.sv]
// Datapath: registers, millisecond converter, progress divider, easing multiplier and output.
`default_nettype none

module etg_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr,
    input  wire logic [etg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [etg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [etg_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic      [etg_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic      [etg_pkg::M_TUSER_W-1:0]     m_tuser,
    input  wire etg_pkg::etg_cmd_t                 cmd,
    output etg_pkg::etg_status_t                   status
);
    import etg_pkg::*;

    // Configuration.
    logic        [DUR_W-1:0]  dur_reg;
    logic        [MODE_W-1:0] mode_reg;
    logic signed [VAL_W-1:0]  start_val_reg;
    logic signed [VAL_W-1:0]  end_val_reg;

    // Input item.
    logic                     kind_reg;

    // Millisecond conversion.
    logic [TIME_BITS-1:0]     ms_t_reg;
    logic [MS_REM_W-1:0]      ms_rem_reg;
    logic [MS_CHUNK_W-1:0]    ms_q_reg;
    logic [MS_PHASE_W-1:0]    ms_cnt_reg;
    logic                     ms_busy_reg;
    logic                     ms_done_reg;
    logic [MS_PART_W-1:0]     ms_part;
    logic [MS_PART_W+MS_RECIP_W-1:0] ms_prod;
    logic [MS_PART_W-1:0]     ms_rem_full;

    // Animation state.
    logic [MS_W-1:0]          start_ms_reg;
    logic [PROG_W-1:0]        last_prog_reg;
    logic                     last_valid_reg;
    logic                     active_reg;

    // Working registers.
    logic [PROG_W-1:0]        x_reg;
    logic [PROG_W-1:0]        alpha_reg, alpha_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PR_W-1:0]   prod_reg;
    logic signed [TOT_W-1:0]  total_reg;

    // Result waiting for the output register.
    logic [VAL_W-1:0]         res_value_reg;
    logic [PROG_W-1:0]        res_prog_reg;
    logic                     res_changed_reg;
    logic                     res_running_reg;

    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;
    logic [M_TUSER_W-1:0]     m_user_reg;

    logic [DUR_W-1:0]         dur_eff;
    logic [DIV_W-1:0]         div_dividend;
    logic [DUR_W-1:0]         div_divisor;
    logic [DIV_W-1:0]         div_quo;
    logic                     div_done;
    logic [MS_W-1:0]          now_ms;
    logic [MS_W-1:0]          elapsed;
    logic                     lower_half;
    logic                     use_comp;
    logic [PROG_W-1:0]        m_val;
    logic [PROG_W:0]          n_val;
    logic signed [MA_W-1:0]   a_op;
    logic signed [MB_W-1:0]   b_op;
    logic [PR_W-1:0]          prod_u;
    logic [PR_W-1:0]          sh_f, sh_fm1, sh_fp1, sh_2f;
    logic signed [TOT_W-1:0]  total_next;
    logic [TOT_W-1:0]         rounded;
    logic                     changed;

    assign dur_eff = (dur_reg == '0) ? DUR_W'(1) : dur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg       <= DUR_RESET;
            mode_reg      <= MODE_RESET;
            start_val_reg <= '0;
            end_val_reg   <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_DURATION: dur_reg       <= cfg_data[DUR_W-1:0];
                CFG_CURVE:    mode_reg      <= cfg_data[MODE_W-1:0];
                CFG_START:    start_val_reg <= cfg_data[VAL_W-1:0];
                CFG_END:      end_val_reg   <= cfg_data[VAL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            kind_reg <= s_tuser;
        end
    end

    // The timestamp is divided by 1000 one 16-bit slice at a time, from the
    // top. Even phases form a quotient digit from the remainder and the top
    // slice; odd phases keep the new remainder and shift the digit in at the
    // bottom, so the whole quotient sits in ms_t_reg after the last phase.
    assign ms_part     = {ms_rem_reg, ms_t_reg[TIME_BITS-1 -: MS_CHUNK_W]};
    assign ms_prod     = ms_part * MS_RECIP;
    assign ms_rem_full = ms_part - ms_q_reg * MS_THOUSAND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_busy_reg <= 1'b0;
            ms_done_reg <= 1'b0;
            ms_cnt_reg  <= '0;
        end else begin
            ms_done_reg <= 1'b0;
            if (cmd.ms_start) begin
                ms_busy_reg <= 1'b1;
                ms_cnt_reg  <= '0;
            end else if (ms_busy_reg) begin
                ms_cnt_reg <= ms_cnt_reg + 1'b1;
                if (ms_cnt_reg == MS_PHASE_W'(2 * MS_STEPS - 1)) begin
                    ms_busy_reg <= 1'b0;
                    ms_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            ms_t_reg <= s_tdata[TIME_BITS-1:0];
        end else if (cmd.ms_start) begin
            ms_rem_reg <= '0;
        end else if (ms_busy_reg) begin
            if (!ms_cnt_reg[0]) begin
                ms_q_reg <= ms_prod[MS_SHIFT +: MS_CHUNK_W];
            end else begin
                ms_rem_reg <= ms_rem_full[MS_REM_W-1:0];
                ms_t_reg   <= {ms_t_reg[TIME_BITS-MS_CHUNK_W-1:0], ms_q_reg};
            end
        end
    end

    // The divider scales the elapsed time into a fraction of the duration.
    assign div_dividend = DIV_W'(elapsed[DUR_W-1:0]) << FRAC_BITS;
    assign div_divisor  = dur_eff;

    etg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign now_ms  = ms_t_reg[MS_W-1:0];
    assign elapsed = (now_ms > start_ms_reg) ? now_ms - start_ms_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.set_x_one) begin
            x_reg <= ONE_Q;
        end else if (cmd.load_x) begin
            x_reg <= div_quo[PROG_W-1:0];
        end
    end

    // Multiplier operands: the curve is folded so that every eased shape is a
    // square or a cube of one term, with an optional (2 - m) factor.
    always_comb begin
        lower_half = x_reg < HALF_Q;
        m_val      = x_reg;
        if (mode_reg == CURVE_OUT_CUBIC) begin
            m_val = ONE_Q - x_reg;
        end else if (mode_reg == CURVE_INOUT_QUAD && !lower_half) begin
            m_val = (x_reg << 1) - ONE_Q;
        end
        use_comp = (mode_reg == CURVE_OUT_QUAD) ||
                   (mode_reg == CURVE_INOUT_QUAD && !lower_half);
        n_val    = use_comp ? TWO_Q - {1'b0, m_val} : {1'b0, m_val};
    end

    always_comb begin
        case (cmd.mul_op)
            MUL_FIRST: begin
                a_op = $signed(MA_W'(n_val));
                b_op = $signed(MB_W'(m_val));
            end
            MUL_CUBE: begin
                a_op = $signed(MA_W'(prod_u[P1_W-1:0]));
                b_op = $signed(MB_W'(m_val));
            end
            MUL_INTERP: begin
                a_op = MA_W'(diff_reg);
                b_op = $signed(MB_W'(alpha_reg));
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= a_op * b_op;
        end
    end

    assign prod_u = $unsigned(prod_reg);
    assign sh_f   = prod_u >> FRAC_BITS;
    assign sh_fm1 = prod_u >> (FRAC_BITS - 1);
    assign sh_fp1 = (prod_u + ONE_SQ) >> (FRAC_BITS + 1);
    assign sh_2f  = prod_u >> (2 * FRAC_BITS);

    always_comb begin
        case (mode_reg)
            CURVE_IN_QUAD:    alpha_next = sh_f[PROG_W-1:0];
            CURVE_INOUT_QUAD: alpha_next = lower_half ? sh_fm1[PROG_W-1:0]
                                                      : sh_fp1[PROG_W-1:0];
            CURVE_OUT_QUAD:   alpha_next = sh_f[PROG_W-1:0];
            CURVE_IN_CUBIC:   alpha_next = sh_2f[PROG_W-1:0];
            CURVE_OUT_CUBIC:  alpha_next = ONE_Q - sh_2f[PROG_W-1:0];
            default:          alpha_next = x_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.alpha_en) begin
            alpha_reg <= alpha_next;
            diff_reg  <= DIFF_W'(end_val_reg) - DIFF_W'(start_val_reg);
        end
    end

    assign total_next = (TOT_W'(start_val_reg) <<< FRAC_BITS) + TOT_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (cmd.total_en) begin
            total_reg <= total_next;
        end
    end

    // Adding one less than the scale to a negative sum turns the floor of
    // the arithmetic shift into truncation toward zero.
    assign rounded = $unsigned(total_reg) +
                     (total_reg[TOT_W-1] ? TOT_W'(ONE_Q - 1'b1) : '0);
    assign changed = !(last_valid_reg && x_reg == last_prog_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ms_reg   <= '0;
            last_prog_reg  <= '0;
            last_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
        end else if (cmd.load_start) begin
            start_ms_reg   <= now_ms;
            active_reg     <= 1'b1;
            last_valid_reg <= 1'b0;
        end else if (cmd.commit_frame) begin
            last_prog_reg  <= x_reg;
            last_valid_reg <= 1'b1;
            if (x_reg[FRAC_BITS]) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            res_value_reg   <= start_val_reg;
            res_prog_reg    <= '0;
            res_changed_reg <= 1'b0;
            res_running_reg <= 1'b1;
        end else if (cmd.res_zero) begin
            res_value_reg   <= '0;
            res_prog_reg    <= '0;
            res_changed_reg <= 1'b0;
            res_running_reg <= 1'b0;
        end else if (cmd.commit_frame) begin
            res_value_reg   <= rounded[FRAC_BITS+VAL_W-1:FRAC_BITS];
            res_prog_reg    <= x_reg;
            res_changed_reg <= changed;
            res_running_reg <= !x_reg[FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= M_TDATA_W'({res_prog_reg, res_value_reg});
            m_user_reg <= {res_running_reg, res_changed_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        status.kind_start = (kind_reg == KIND_START);
        status.active     = active_reg;
        status.elapsed_ge = elapsed >= MS_W'(dur_eff);
        status.ms_done    = ms_done_reg;
        status.div_done   = div_done;
        status.cubic      = (mode_reg == CURVE_IN_CUBIC) || (mode_reg == CURVE_OUT_CUBIC);
        status.out_free   = !m_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

[rtl/etg_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
`default_nettype none

module etg_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire etg_pkg::etg_status_t  status,
    output etg_pkg::etg_cmd_t          cmd
);
    import etg_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_LAUNCH = 12'b0000_0000_0010,
        ST_DIVMS  = 12'b0000_0000_0100,
        ST_DECIDE = 12'b0000_0000_1000,
        ST_DIVX   = 12'b0000_0001_0000,
        ST_MUL1   = 12'b0000_0010_0000,
        ST_MUL2   = 12'b0000_0100_0000,
        ST_ALPHA  = 12'b0000_1000_0000,
        ST_MUL3   = 12'b0001_0000_0000,
        ST_TOTAL  = 12'b0010_0000_0000,
        ST_ROUND  = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } etg_state_t;

    etg_state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_FIRST;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                cmd.ms_start = 1'b1;
                state_next   = ST_DIVMS;
            end
            ST_DIVMS: begin
                if (status.ms_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.kind_start) begin
                    cmd.load_start = 1'b1;
                    state_next     = ST_OUT;
                end else if (!status.active) begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_OUT;
                end else if (status.elapsed_ge) begin
                    cmd.set_x_one = 1'b1;
                    state_next    = ST_MUL1;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVX;
                end
            end
            ST_DIVX: begin
                if (status.div_done) begin
                    cmd.load_x = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_FIRST;
                state_next = status.cubic ? ST_MUL2 : ST_ALPHA;
            end
            ST_MUL2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_CUBE;
                state_next = ST_ALPHA;
            end
            ST_ALPHA: begin
                cmd.alpha_en = 1'b1;
                state_next   = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_INTERP;
                state_next = ST_TOTAL;
            end
            ST_TOTAL: begin
                cmd.total_en = 1'b1;
                state_next   = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.commit_frame = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT: begin
                // Wait until the output register is free or being emptied.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[tb/tb_eased_tween_generator.sv]
// Self-checking testbench for the eased tween generator: directed tweens, then random ones.
`timescale 1ns / 100ps

module tb_eased_tween_generator;

    import etg_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int SETTLE_CYCLES = 200;
    localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;
    localparam logic KIND_FRAME = ~KIND_START;
    localparam logic [MODE_W-1:0] CURVE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] CURVE_SPARE_HI = 3'd7;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_phase_t;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [PROG_W-1:0] progress;
        logic              changed;
        logic              running;
    } tween_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Predictor copy of the registers and the animation state.
    logic [DUR_W-1:0]  cur_duration = DUR_RESET;
    logic [MODE_W-1:0] cur_curve = MODE_RESET;
    logic [VAL_W-1:0]  cur_start_val = '0;
    logic [VAL_W-1:0]  cur_end_val = '0;
    longint unsigned   anim_start_ms = 0;
    longint unsigned   prev_progress = 0;
    bit                prev_valid = 1'b0;
    bit                anim_active = 1'b0;

    tween_res_t expected_tweens[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_starts = 0;
    int n_results = 0;
    int n_completions = 0;
    int n_cfg_writes = 0;

    eased_tween_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic longint unsigned ease_alpha(input logic [MODE_W-1:0] curve,
                                                   input longint unsigned x);
        longint unsigned u;
        case (curve)
            CURVE_IN_QUAD:  return (x * x) >> FRAC_BITS;
            CURVE_INOUT_QUAD: begin
                if (2 * x < UNIT)
                    return (x * x) >> (FRAC_BITS - 1);
                u = 2 * x - UNIT;
                return (u * (2 * UNIT - u) + UNIT * UNIT) >> (FRAC_BITS + 1);
            end
            CURVE_OUT_QUAD: return (x * (2 * UNIT - x)) >> FRAC_BITS;
            // Cubes of a Q1.16 value fit in 64 bits, so the floor is exact.
            CURVE_IN_CUBIC: return (x * x * x) >> (2 * FRAC_BITS);
            CURVE_OUT_CUBIC: begin
                u = UNIT - x;
                return UNIT - ((u * u * u) >> (2 * FRAC_BITS));
            end
            default: return x;
        endcase
    endfunction

    task automatic predict_tween(input logic kind, input logic [TIME_BITS-1:0] t_us,
                                 output tween_res_t res);
        longint unsigned t64, now_ms, dur, elapsed, x, alpha;
        longint total;
        t64 = t_us;
        now_ms = t64 / MS_DIV;
        res = '0;
        if (kind == KIND_START) begin
            anim_start_ms = now_ms;
            anim_active = 1'b1;
            prev_valid = 1'b0;
            res.value = cur_start_val;
            res.running = 1'b1;
            return;
        end
        if (!anim_active)
            return;
        dur = (cur_duration == 0) ? 1 : cur_duration;
        elapsed = (now_ms > anim_start_ms) ? now_ms - anim_start_ms : 0;
        x = (elapsed >= dur) ? UNIT : (elapsed * UNIT) / dur;
        alpha = ease_alpha(cur_curve, x);
        total = longint'($signed(cur_start_val)) * longint'(UNIT)
              + (longint'($signed(cur_end_val)) - longint'($signed(cur_start_val)))
                * longint'(alpha);
        // Signed division truncates toward zero, as the interpolation requires.
        res.value = VAL_W'(total / longint'(UNIT));
        res.progress = PROG_W'(x);
        res.changed = !(prev_valid && x == prev_progress);
        res.running = (x < UNIT);
        prev_progress = x;
        prev_valid = 1'b1;
        if (x >= UNIT)
            anim_active = 1'b0;
    endtask

    task automatic send_item(input logic kind, input logic [TIME_BITS-1:0] t_us);
        tween_res_t res;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= S_TDATA_W'({$urandom, $urandom});
            s_tuser <= 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(t_us);
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_tween(kind, t_us, res);
        expected_tweens.push_back(res);
        n_items++;
        if (kind == KIND_START)
            n_starts++;
    endtask

    // Lowers the input valid and waits until every expected result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_tweens.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_DURATION: cur_duration = data[DUR_W-1:0];
            CFG_CURVE:    cur_curve = data[MODE_W-1:0];
            CFG_START:    cur_start_val = data;
            CFG_END:      cur_end_val = data;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input idle_phase_t phase);
        case (phase)
            IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 64; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 64; end
            default:       begin src_idle_pct = 18; sink_stall_pct = 18; end
        endcase
    endtask

    always @(posedge aclk) begin : check_results
        tween_res_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[VAL_W-1:0];
            got.progress = m_tdata[VAL_W +: PROG_W];
            got.changed = m_tuser[0];
            got.running = m_tuser[1];
            n_results++;
            if (got.progress == PROG_W'(UNIT) && !got.running)
                n_completions++;
            if (expected_tweens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with nothing expected: value %0d progress %0d",
                             $realtime, $signed(got.value), got.progress);
            end else begin
                want = expected_tweens.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: expected value %0d progress %0d changed %0b running %0b,",
                                  " got value %0d progress %0d changed %0b running %0b"},
                                 $realtime, $signed(want.value), want.progress, want.changed,
                                 want.running, $signed(got.value), got.progress, got.changed,
                                 got.running);
                end
            end
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        // Keep headroom below the top so a sequence of frames does not wrap.
        if (r[TIME_BITS-1 -: 4] == 4'hF)
            r[TIME_BITS-1] = 1'b0;
        return r[TIME_BITS-1:0];
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DUR_W'(1);
            2: return '1;
            3, 4: return DUR_W'($urandom_range(2, 40));
            5: return DUR_W'($urandom_range(41, 1000));
            default: return DUR_W'($urandom);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 6))
            0: return {1'b1, {(VAL_W - 1){1'b0}}};
            1: return {1'b0, {(VAL_W - 1){1'b1}}};
            2: return '0;
            3: return VAL_W'($urandom_range(0, 2000)) - VAL_W'(1000);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic test_idle_frame();
        set_idling(IDLE_NONE);
        send_item(KIND_FRAME, '0);
        drain_results();
    endtask

    // Reset duration and curve, covering a repeated millisecond, completion
    // and a frame after the animation has finished.
    task automatic test_default_tween();
        write_reg(CFG_START, -32'sd100000);
        write_reg(CFG_END, 32'sd300000);
        send_item(KIND_START, TIME_BITS'(1_000_000));
        send_item(KIND_FRAME, TIME_BITS'(1_062_500));
        send_item(KIND_FRAME, TIME_BITS'(1_062_999));
        send_item(KIND_FRAME, TIME_BITS'(1_250_000));
        send_item(KIND_FRAME, TIME_BITS'(1_400_000));
        drain_results();
    endtask

    task automatic check_curve(input logic [MODE_W-1:0] curve, input int frame_ms);
        write_reg(CFG_CURVE, CFG_DATA_W'(curve));
        send_item(KIND_START, '0);
        send_item(KIND_FRAME, TIME_BITS'(frame_ms * MS_DIV + 321));
        drain_results();
    endtask

    task automatic test_curve_modes();
        set_idling(IDLE_BOTH);
        write_reg(CFG_DURATION, CFG_DATA_W'(100));
        write_reg(CFG_START, {1'b1, {(VAL_W - 1){1'b0}}});
        write_reg(CFG_END, {1'b0, {(VAL_W - 1){1'b1}}});
        check_curve(CURVE_LINEAR, 10);
        check_curve(CURVE_IN_QUAD, 21);
        check_curve(CURVE_INOUT_QUAD, 32);
        check_curve(CURVE_OUT_QUAD, 43);
        check_curve(CURVE_IN_CUBIC, 54);
        check_curve(CURVE_OUT_CUBIC, 65);
        check_curve(CURVE_SPARE_LO, 76);
        check_curve(CURVE_SPARE_HI, 87);
    endtask

    // Zero duration, timestamps at both ends of the range, a clock that runs
    // backwards and a restart while the animation is still running.
    task automatic test_time_extremes();
        write_reg(CFG_DURATION, '0);
        write_reg(CFG_CURVE, CFG_DATA_W'(CURVE_LINEAR));
        send_item(KIND_START, '1);
        send_item(KIND_FRAME, '0);
        send_item(KIND_START, TIME_BITS'(5000));
        send_item(KIND_FRAME, '1);
        drain_results();
    endtask

    task automatic run_tween_sequence();
        logic [TIME_BITS-1:0] t;
        longint unsigned span_us, step_max;
        int frames;
        t = rand_time();
        send_item(KIND_START, t);
        frames = $urandom_range(1, 8);
        span_us = ((cur_duration == 0) ? 64'd1 : 64'(cur_duration)) * MS_DIV;
        step_max = span_us * 3 / (2 * frames);
        repeat (frames) begin
            case ($urandom_range(0, 11))
                0: ;
                1: t -= TIME_BITS'($urandom_range(0, 5000));
                2: t += TIME_BITS'($urandom_range(0, 1999));
                3: send_item(KIND_START, t);
                default: t += TIME_BITS'($urandom_range(0, 32'(step_max)));
            endcase
            send_item(KIND_FRAME, t);
        end
        if ($urandom_range(0, 3) == 0)
            send_item(KIND_FRAME, t + TIME_BITS'(span_us));
    endtask

    task automatic test_random_tweens();
        int first_item, round;
        first_item = n_items;
        round = 0;
        while (n_items - first_item < RANDOM_ITEMS) begin
            drain_results();
            set_idling(idle_phase_t'(round % 4));
            // Data bits above the duration and curve widths carry junk on purpose.
            write_reg(CFG_DURATION, {16'($urandom), pick_duration()});
            write_reg(CFG_CURVE, $urandom);
            write_reg(CFG_START, pick_value());
            write_reg(CFG_END, pick_value());
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(99) < 15)
                    send_item(1'($urandom), rand_time());
                else
                    run_tween_sequence();
            end
            round++;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_frame();
        test_default_tween();
        test_curve_modes();
        test_time_extremes();
        test_random_tweens();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d items (%0d starts, %0d frames) over %0d register writes.",
                 n_items, n_starts, n_items - n_starts, n_cfg_writes);
        $display("Checked %0d results, %0d of them completing an animation.",
                 n_results, n_completions);
        if (mismatches == 0 && expected_tweens.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
